FILE: sv/psd_pkg.sv
package psd_pkg;

	localparam int CW = 33;
	localparam int PW = 66;
	localparam int DTW = 67;
	localparam int NW = 132;
	localparam int QW = 68;
	localparam int REMW = 134;
	localparam int SW = 34;
	localparam int TOLW = 32;

	typedef enum logic [1:0] {
		CASE_DEGEN  = 2'd0,
		CASE_FIRST  = 2'd1,
		CASE_SECOND = 2'd2,
		CASE_PERP   = 2'd3
	} case_t;

	typedef struct packed {
		logic valid;
		case_t code;
		logic [NW-1:0] num;
		logic [PW-1:0] den;
	} div_in_t;

	typedef struct packed {
		logic valid;
		case_t code;
		logic [QW-1:0] rad;
	} root_in_t;

	typedef struct packed {
		logic valid;
		case_t code;
		logic [SW-1:0] root;
	} root_out_t;

endpackage

FILE: sv/psd_front.sv
module psd_front
	import psd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic [2:0][31:0] p,
	input  logic [2:0][31:0] a,
	input  logic [2:0][31:0] b,
	input  logic fb,
	input  logic sb,
	input  logic [TOLW-1:0] tol,
	output div_in_t dout
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic signed [CW-1:0] lv_s1 [3];
	logic signed [CW-1:0] pv_s1 [3];
	logic signed [CW-1:0] qv_s1 [3];
	logic fb_s1, sb_s1;

	logic signed [PW-1:0] ll_s2 [3];
	logic signed [PW-1:0] pl_s2 [3];
	logic signed [PW-1:0] pp_s2 [3];
	logic signed [PW-1:0] qq_s2 [3];
	logic signed [PW-1:0] xa_s2 [3];
	logic signed [PW-1:0] xb_s2 [3];
	logic fb_s2, sb_s2;

	logic [PW-1:0] dsq_s3, npv_s3, nqv_s3;
	logic signed [DTW-1:0] dot_s3;
	logic signed [DTW-1:0] cr_s3 [3];
	logic fb_s3, sb_s3;

	logic [PW-1:0] dsq_s4, sel_s4;
	logic [PW-1:0] crm_s4 [3];
	case_t code_s4;

	logic [PW-1:0] hh_s5 [3];
	logic [PW-1:0] hl_s5 [3];
	logic [PW-1:0] lo_s5 [3];
	logic [PW-1:0] dsq_s5, sel_s5;
	case_t code_s5;

	logic [NW-1:0] num_s6;
	logic [PW-1:0] den_s6;
	case_t code_s6;

	case_t code_c;
	logic [PW-1:0] sel_c;
	logic [PW-1:0] crm_c [3];
	logic [NW-1:0] nsum_c;
	logic [NW-1:0] sq_c [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_comb begin
		priority if (dsq_s3 <= PW'(tol)) begin
			code_c = CASE_DEGEN;
			sel_c = npv_s3;
		end else if (fb_s3 && dot_s3[DTW-1]) begin
			code_c = CASE_FIRST;
			sel_c = npv_s3;
		end else if (sb_s3 && ($signed({1'b0, dsq_s3}) < dot_s3)) begin
			code_c = CASE_SECOND;
			sel_c = nqv_s3;
		end else begin
			code_c = CASE_PERP;
			sel_c = npv_s3;
		end
		for (int i = 0; i < 3; i++) begin
			crm_c[i] = cr_s3[i][DTW-1] ? PW'(-cr_s3[i]) : PW'(cr_s3[i]);
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sq_c[i] = (NW'(hh_s5[i]) << PW) + (NW'(hl_s5[i]) << (CW + 1)) + NW'(lo_s5[i]);
		end
		nsum_c = sq_c[0] + sq_c[1] + sq_c[2];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				lv_s1[i] <= $signed({b[i][31], b[i]}) - $signed({a[i][31], a[i]});
				pv_s1[i] <= $signed({p[i][31], p[i]}) - $signed({a[i][31], a[i]});
				qv_s1[i] <= $signed({p[i][31], p[i]}) - $signed({b[i][31], b[i]});
				ll_s2[i] <= lv_s1[i] * lv_s1[i];
				pl_s2[i] <= pv_s1[i] * lv_s1[i];
				pp_s2[i] <= pv_s1[i] * pv_s1[i];
				qq_s2[i] <= qv_s1[i] * qv_s1[i];
				cr_s3[i] <= DTW'(xa_s2[i]) - DTW'(xb_s2[i]);
				crm_s4[i] <= crm_c[i];
				hh_s5[i] <= crm_s4[i][PW-1:CW] * crm_s4[i][PW-1:CW];
				hl_s5[i] <= crm_s4[i][PW-1:CW] * crm_s4[i][CW-1:0];
				lo_s5[i] <= crm_s4[i][CW-1:0] * crm_s4[i][CW-1:0];
			end
			fb_s1 <= fb;
			sb_s1 <= sb;
			xa_s2[0] <= pv_s1[1] * lv_s1[2];
			xb_s2[0] <= pv_s1[2] * lv_s1[1];
			xa_s2[1] <= pv_s1[2] * lv_s1[0];
			xb_s2[1] <= pv_s1[0] * lv_s1[2];
			xa_s2[2] <= pv_s1[0] * lv_s1[1];
			xb_s2[2] <= pv_s1[1] * lv_s1[0];
			fb_s2 <= fb_s1;
			sb_s2 <= sb_s1;
			dsq_s3 <= ll_s2[0][PW-1:0] + ll_s2[1][PW-1:0] + ll_s2[2][PW-1:0];
			npv_s3 <= pp_s2[0][PW-1:0] + pp_s2[1][PW-1:0] + pp_s2[2][PW-1:0];
			nqv_s3 <= qq_s2[0][PW-1:0] + qq_s2[1][PW-1:0] + qq_s2[2][PW-1:0];
			dot_s3 <= DTW'(pl_s2[0]) + DTW'(pl_s2[1]) + DTW'(pl_s2[2]);
			fb_s3 <= fb_s2;
			sb_s3 <= sb_s2;
			dsq_s4 <= dsq_s3;
			sel_s4 <= sel_c;
			code_s4 <= code_c;
			dsq_s5 <= dsq_s4;
			sel_s5 <= sel_s4;
			code_s5 <= code_s4;
			code_s6 <= code_s5;
			num_s6 <= (code_s5 == CASE_PERP) ? nsum_c : NW'(sel_s5);
			den_s6 <= (code_s5 == CASE_PERP) ? dsq_s5 : PW'(1);
		end
	end

	assign dout = '{valid: v_s6, code: code_s6, num: num_s6, den: den_s6};

	a_unit_den: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 && code_s6 != CASE_PERP |-> den_s6 == PW'(1))
		else $error("Clamped or degenerate item carries a divisor other than one.");

endmodule

FILE: sv/psd_div.sv
module psd_div
	import psd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  div_in_t din,
	output root_in_t dout
);

	logic v_s [QW];
	case_t code_s [QW];
	logic [QW-1:0] q_s [QW];
	logic [REMW-1:0] rem_s [QW-1];
	logic [PW-1:0] den_s [QW-1];

	for (genvar g = 0; g < QW; g++) begin : g_stage
		localparam int K = QW - 1 - g;
		logic vi;
		case_t ci;
		logic [REMW-1:0] ri;
		logic [PW-1:0] di;
		logic [QW-1:0] qi;
		logic [REMW-1:0] dsh;
		logic ge;

		if (g == 0) begin : g_head
			assign vi = din.valid;
			assign ci = din.code;
			assign ri = REMW'(din.num);
			assign di = din.den;
			assign qi = '0;
		end else begin : g_body
			assign vi = v_s[g-1];
			assign ci = code_s[g-1];
			assign ri = rem_s[g-1];
			assign di = den_s[g-1];
			assign qi = q_s[g-1];
		end

		assign dsh = REMW'(di) << K;
		assign ge = ri >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else if (en) begin
				v_s[g] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				code_s[g] <= ci;
				q_s[g] <= {qi[QW-2:0], ge};
			end
		end

		if (g < QW - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[g] <= ge ? ri - dsh : ri;
					den_s[g] <= di;
				end
			end
		end
	end

	assign dout = '{valid: v_s[QW-1], code: code_s[QW-1], rad: q_s[QW-1]};

	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		din.valid |-> din.den != '0)
		else $error("Item enters the divider with a zero divisor.");

endmodule

FILE: sv/psd_sqrt.sv
module psd_sqrt
	import psd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  root_in_t din,
	output root_out_t dout
);

	logic v_s [SW];
	case_t code_s [SW];
	logic [QW-1:0] res_s [SW];
	logic [QW-1:0] op_s [SW-1];

	for (genvar g = 0; g < SW; g++) begin : g_stage
		localparam int B = SW - 1 - g;
		localparam logic [QW-1:0] ONE = QW'(1) << (2 * B);
		logic vi;
		case_t ci;
		logic [QW-1:0] oi;
		logic [QW-1:0] ri;
		logic [QW-1:0] trial;
		logic ge;

		if (g == 0) begin : g_head
			assign vi = din.valid;
			assign ci = din.code;
			assign oi = din.rad;
			assign ri = '0;
		end else begin : g_body
			assign vi = v_s[g-1];
			assign ci = code_s[g-1];
			assign oi = op_s[g-1];
			assign ri = res_s[g-1];
		end

		assign trial = ri + ONE;
		assign ge = oi >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else if (en) begin
				v_s[g] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				code_s[g] <= ci;
				res_s[g] <= ge ? (ri >> 1) + ONE : ri >> 1;
			end
		end

		if (g < SW - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					op_s[g] <= ge ? oi - trial : oi;
				end
			end
		end
	end

	assign dout = '{valid: v_s[SW-1], code: code_s[SW-1], root: res_s[SW-1][SW-1:0]};

	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[SW-1] |-> res_s[SW-1][QW-1:SW] == '0)
		else $error("Square root result exceeds its width.");

endmodule

FILE: sv/point_segment_distance_3d_unit.sv
// The pipeline has 6 arithmetic stages, 68 restoring divider stages
// and 34 square root stages.
// Throughput: one item per cycle; the whole pipeline holds while a result waits
// at the output and out_ready is low.
// Reset clears every valid bit and sets the tolerance register to one.
module point_segment_distance_3d_unit
	import psd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [31:0] point_x,
	input  logic [31:0] point_y,
	input  logic [31:0] point_z,
	input  logic [31:0] first_x,
	input  logic [31:0] first_y,
	input  logic [31:0] first_z,
	input  logic [31:0] second_x,
	input  logic [31:0] second_y,
	input  logic [31:0] second_z,
	input  logic first_end_bounded,
	input  logic second_end_bounded,
	output logic out_valid,
	input  logic out_ready,
	output logic [32:0] distance,
	output logic [1:0] case_code,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [31:0] cfg_data
);

	logic [TOLW-1:0] tol_q;
	logic en;
	div_in_t div_in;
	root_in_t root_in;
	root_out_t root_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOLW'(1);
		end else if (cfg_valid && cfg_ready) begin
			tol_q <= cfg_data;
		end
	end

	assign en = !root_out.valid || out_ready;
	assign in_ready = en;

	psd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(in_valid),
		.p({point_z, point_y, point_x}),
		.a({first_z, first_y, first_x}),
		.b({second_z, second_y, second_x}),
		.fb(first_end_bounded),
		.sb(second_end_bounded),
		.tol(tol_q),
		.dout(div_in)
	);

	psd_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.din(div_in),
		.dout(root_in)
	);

	psd_sqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.din(root_in),
		.dout(root_out)
	);

	assign out_valid = root_out.valid;
	assign distance = root_out.root[32:0];
	assign case_code = root_out.code;

endmodule

FILE: verif/point_segment_distance_3d_checker.sv
module point_segment_distance_3d_checker
	import psd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_ready,
	input  logic [2:0][31:0] point,
	input  logic [2:0][31:0] first,
	input  logic [2:0][31:0] second,
	input  logic first_end_bounded,
	input  logic second_end_bounded,
	input  logic out_valid,
	input  logic out_ready,
	input  logic [32:0] distance,
	input  logic [1:0] case_code,
	input  logic cfg_valid,
	input  logic cfg_ready,
	input  logic [31:0] cfg_data,
	output int errors,
	output int pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [191:0] wide_t;

	typedef struct packed {
		logic [32:0] magnitude;
		case_t code;
	} distance_result_t;

	distance_result_t expected_distances[$];
	logic [31:0] tolerance;

	function automatic logic [32:0] root_of_ratio(input logic [191:0] num, input logic [191:0] den);
		logic [33:0] q;
		logic [33:0] c;
		logic [191:0] cw;
		q = '0;
		for (int b = 33; b >= 0; b--) begin
			c = q | (34'd1 << b);
			cw = 192'(c);
			if (cw * cw * den <= num) begin
				q = c;
			end
		end
		return q[32:0];
	endfunction

	function automatic distance_result_t predict_distance(
		input logic [2:0][31:0] p,
		input logic [2:0][31:0] a,
		input logic [2:0][31:0] b,
		input logic fb,
		input logic sb,
		input logic [31:0] tol
	);
		wide_t pv[3];
		wide_t lv[3];
		wide_t qv[3];
		wide_t dsq;
		wide_t dot;
		wide_t cx;
		wide_t cy;
		wide_t cz;
		wide_t pa_sq;
		wide_t pb_sq;
		distance_result_t r;
		for (int i = 0; i < 3; i++) begin
			pv[i] = wide_t'($signed(p[i])) - wide_t'($signed(a[i]));
			lv[i] = wide_t'($signed(b[i])) - wide_t'($signed(a[i]));
			qv[i] = wide_t'($signed(p[i])) - wide_t'($signed(b[i]));
		end
		dsq = lv[0] * lv[0] + lv[1] * lv[1] + lv[2] * lv[2];
		dot = pv[0] * lv[0] + pv[1] * lv[1] + pv[2] * lv[2];
		pa_sq = pv[0] * pv[0] + pv[1] * pv[1] + pv[2] * pv[2];
		pb_sq = qv[0] * qv[0] + qv[1] * qv[1] + qv[2] * qv[2];
		if (dsq <= $signed({160'd0, tol})) begin
			r.magnitude = root_of_ratio(pa_sq, 192'd1);
			r.code = CASE_DEGEN;
		end else if (fb && dot < 0) begin
			r.magnitude = root_of_ratio(pa_sq, 192'd1);
			r.code = CASE_FIRST;
		end else if (sb && (dsq - dot) < 0) begin
			r.magnitude = root_of_ratio(pb_sq, 192'd1);
			r.code = CASE_SECOND;
		end else begin
			cx = pv[1] * lv[2] - pv[2] * lv[1];
			cy = pv[2] * lv[0] - pv[0] * lv[2];
			cz = pv[0] * lv[1] - pv[1] * lv[0];
			r.magnitude = root_of_ratio(cx * cx + cy * cy + cz * cz, dsq);
			r.code = CASE_PERP;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		distance_result_t got;
		distance_result_t want;
		if (!arst_n) begin
			tolerance = 32'd1;
			errors = 0;
			pending = 0;
			expected_distances.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				tolerance = cfg_data;
			end
			if (in_valid && in_ready) begin
				expected_distances.push_back(predict_distance(point, first, second,
					first_end_bounded, second_end_bounded, tolerance));
			end
			if (out_valid && out_ready) begin
				got.magnitude = distance;
				got.code = case_t'(case_code);
				if (expected_distances.size() == 0) begin
					$display("%0t: result with nothing expected: distance %0d case %0d",
						$time, got.magnitude, got.code);
					errors++;
				end else begin
					want = expected_distances.pop_front();
					if (got.magnitude !== want.magnitude) begin
						$display("%0t: distance mismatch: expected %0d actual %0d",
							$time, want.magnitude, got.magnitude);
						errors++;
					end
					if (got.code !== want.code) begin
						$display("%0t: case_code mismatch: expected %0d actual %0d",
							$time, want.code, got.code);
						errors++;
					end
				end
			end
			pending = expected_distances.size();
		end
	end

endmodule

FILE: verif/point_segment_distance_3d_unit_tb.sv
module point_segment_distance_3d_unit_tb;
	import psd_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [2:0][31:0] p;
		logic [2:0][31:0] a;
		logic [2:0][31:0] b;
		logic fb;
		logic sb;
	} query_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [2:0][31:0] point;
	logic [2:0][31:0] first;
	logic [2:0][31:0] second;
	logic first_end_bounded;
	logic second_end_bounded;
	logic out_valid;
	logic out_ready;
	logic [32:0] distance;
	logic [1:0] case_code;
	logic cfg_valid;
	logic cfg_ready;
	logic [31:0] cfg_data;
	int errors;
	int pending;
	int send_idle_pct;
	int recv_idle_pct;
	logic hold_request;

	point_segment_distance_3d_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.point_x(point[0]),
		.point_y(point[1]),
		.point_z(point[2]),
		.first_x(first[0]),
		.first_y(first[1]),
		.first_z(first[2]),
		.second_x(second[0]),
		.second_y(second[1]),
		.second_z(second[2]),
		.first_end_bounded(first_end_bounded),
		.second_end_bounded(second_end_bounded),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.distance(distance),
		.case_code(case_code),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	point_segment_distance_3d_checker distance_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.point(point),
		.first(first),
		.second(second),
		.first_end_bounded(first_end_bounded),
		.second_end_bounded(second_end_bounded),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.distance(distance),
		.case_code(case_code),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.errors(errors),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#3ms;
		$display("point_segment_distance_3d_unit regression: fail");
		$finish;
	end

	// The receiver owns out_ready; a hold request stalls it for a long stretch.
	initial begin
		int hold_left;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request && hold_left == 0) begin
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	function automatic logic [31:0] near(input logic [31:0] base, input int span);
		return base + 32'($signed($urandom_range(2 * span)) - span);
	endfunction

	function automatic query_t random_query();
		query_t q;
		int shape;
		shape = $urandom_range(9);
		for (int i = 0; i < 3; i++) begin
			unique case (shape)
				0, 1, 2: begin
					q.p[i] = $urandom;
					q.a[i] = $urandom;
					q.b[i] = $urandom;
				end
				3, 4, 5, 6: begin
					q.a[i] = near(32'd0, 1 << 20);
					q.b[i] = near(q.a[i], 1 << 18);
					q.p[i] = near(q.a[i], 1 << 19);
				end
				7, 8: begin
					q.a[i] = $urandom;
					q.b[i] = near(q.a[i], 3);
					q.p[i] = near(q.a[i], 1 << 16);
				end
				default: begin
					q.a[i] = $urandom;
					q.b[i] = near(q.a[i], 1 << 24);
					q.p[i] = near(q.b[i], 1 << 25);
				end
			endcase
		end
		q.fb = 1'($urandom_range(1));
		q.sb = 1'($urandom_range(1));
		return q;
	endfunction

	function automatic query_t make_query(input int px, py, pz, ax, ay, az, bx, by, bz,
		input int fb, input int sb);
		query_t q;
		q.p = {32'(pz), 32'(py), 32'(px)};
		q.a = {32'(az), 32'(ay), 32'(ax)};
		q.b = {32'(bz), 32'(by), 32'(bx)};
		q.fb = fb[0];
		q.sb = sb[0];
		return q;
	endfunction

	task automatic send_query(input query_t q, input logic may_idle);
		logic ready_seen;
		if (may_idle && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		point <= q.p;
		first <= q.a;
		second <= q.b;
		first_end_bounded <= q.fb;
		second_end_bounded <= q.sb;
		do begin
			@(negedge clk);
			ready_seen = in_ready;
			@(posedge clk);
		end while (!ready_seen);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_tolerance(input logic [31:0] value);
		logic ready_seen;
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do begin
			@(negedge clk);
			ready_seen = cfg_ready;
			@(posedge clk);
		end while (!ready_seen);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(input int count);
		for (int n = 0; n < count; n++) begin
			send_query(random_query(), 1'b1);
		end
		drain();
	endtask

	localparam int MAXC = 32'h7fffffff;
	localparam int MINC = 32'h80000000;

	initial begin
		query_t directed[$];
		arst_n = 1'b0;
		in_valid = 1'b0;
		point = '0;
		first = '0;
		second = '0;
		first_end_bounded = 1'b0;
		second_end_bounded = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		hold_request = 1'b0;
		send_idle_pct = 15;
		recv_idle_pct = 45;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed.push_back(make_query(MAXC, MAXC, MAXC, MINC, MINC, MINC, MINC, MINC, MINC, 1, 1));
		directed.push_back(make_query(MINC, MINC, MINC, MAXC, MAXC, MAXC, MINC, MINC, MINC, 1, 1));
		directed.push_back(make_query(MINC, MAXC, MINC, MAXC, MINC, MAXC, MINC, MAXC, MINC, 0, 0));
		directed.push_back(make_query(MAXC, MINC, 0, MINC, MAXC, MINC, MAXC, MINC, MAXC, 0, 0));
		directed.push_back(make_query(5, 7, 9, 0, 0, 0, 1, 0, 0, 1, 1));
		directed.push_back(make_query(5, 7, 9, 0, 0, 0, 1, 1, 0, 1, 1));
		directed.push_back(make_query(-500, 300, 0, 0, 0, 0, 1000, 0, 0, 1, 0));
		directed.push_back(make_query(-500, 300, 0, 0, 0, 0, 1000, 0, 0, 0, 1));
		directed.push_back(make_query(1500, 300, 7, 0, 0, 0, 1000, 0, 0, 0, 1));
		directed.push_back(make_query(1500, 300, 7, 0, 0, 0, 1000, 0, 0, 1, 0));
		directed.push_back(make_query(0, 300, 0, 0, 0, 0, 1000, 0, 0, 1, 1));
		directed.push_back(make_query(1000, 300, 0, 0, 0, 0, 1000, 0, 0, 1, 1));
		directed.push_back(make_query(400, 300, -20, 0, 0, 0, 1000, 50, 0, 1, 1));
		directed.push_back(make_query(-65536, 65536, 3, 65536, 0, 0, 65536, 131072, 9, 0, 0));
		directed.push_back(make_query(0, 0, 0, MAXC, 0, 0, MINC, 0, 0, 1, 1));
		directed.push_back(make_query(MAXC, MAXC, MAXC, 0, 0, 0, MINC, MINC, MINC, 1, 1));
		directed.push_back(make_query(-1, -1, -1, -1, -1, -1, -1, -1, -1, 0, 1));
		directed.push_back(make_query(3, 4, 12, 0, 0, 0, 0, 0, 0, 1, 0));
		foreach (directed[i]) send_query(directed[i], 1'b1);
		drain();

		random_phase(110);
		write_tolerance(32'd0);
		foreach (directed[i]) send_query(directed[i], 1'b1);
		random_phase(100);

		send_idle_pct = 45;
		recv_idle_pct = 15;
		write_tolerance(32'hffffffff);
		random_phase(100);
		write_tolerance($urandom);
		random_phase(60);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_tolerance(32'h0001_0000);
		hold_request <= 1'b1;
		@(posedge clk);
		hold_request <= 1'b0;
		random_phase(244);

		if (errors == 0 && pending == 0) begin
			$display("point_segment_distance_3d_unit regression: pass");
		end else begin
			$display("point_segment_distance_3d_unit regression: fail");
		end
		$finish;
	end

endmodule
